// File: rtl/core/repo_pkg.sv
// ----------------------------------------------------------------------------
// Rotated ellipse pair overlap package
// Fixed-point constants, payload types and the elaboration-time trig tables.
// ----------------------------------------------------------------------------
package repo_pkg;

  localparam int SAMPLES         = 8;
  localparam int TRIG_INDEX_BITS = 12;
  localparam int TRIG_N          = 1 << TRIG_INDEX_BITS;
  localparam int TRIG_Q          = TRIG_N >> 2;
  localparam int QA_W            = TRIG_INDEX_BITS - 1;
  localparam int LANES           = 2 * SAMPLES + 2;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [15:0]        rh;
    logic [15:0]        rv;
  } geo_t;

  typedef struct packed {
    geo_t               g;
    logic signed [15:0] c;
    logic signed [15:0] s;
  } ell_t;

  typedef logic [14:0]        qtab_t [0:TRIG_Q];
  typedef logic signed [15:0] stab_t [SAMPLES];

  // Quarter-wave sine of step r by a Q30 Taylor series, rounded to Q15.
  function automatic logic [14:0] quarter_sine(input int unsigned r);
    logic [63:0]        th;
    logic [63:0]        th2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    th   = (64'(r) * HALF_PI_Q30 + 64'(TRIG_Q / 2)) / 64'(TRIG_Q);
    th2  = (th * th) >> 30;
    term = th;
    sum  = signed'(th);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * th2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v[14:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i <= TRIG_Q; i++) begin
      t[i] = quarter_sine(i);
    end
    return t;
  endfunction

  // Full-turn table entry, extended from the quarter wave by symmetry.
  function automatic logic signed [15:0] trig_entry(input int unsigned i);
    int unsigned        quad;
    int unsigned        r;
    logic signed [15:0] v;
    quad = (i / TRIG_Q) % 4;
    r    = i % TRIG_Q;
    v    = (quad % 2 == 1) ? signed'({1'b0, quarter_sine(TRIG_Q - r)})
                           : signed'({1'b0, quarter_sine(r)});
    return (quad >= 2) ? -v : v;
  endfunction

  function automatic stab_t build_samp(input bit want_cos);
    stab_t       t;
    int unsigned idx;
    for (int k = 0; k < SAMPLES; k++) begin
      idx  = (k * TRIG_N) / SAMPLES;
      t[k] = want_cos ? trig_entry((idx + TRIG_Q) % TRIG_N) : trig_entry(idx);
    end
    return t;
  endfunction

  localparam qtab_t QTAB     = build_qtab();
  localparam stab_t SAMP_COS = build_samp(1'b1);
  localparam stab_t SAMP_SIN = build_samp(1'b0);

  // Lanes below SAMPLES and the first center lane test against the second
  // ellipse; the others test against the first.
  function automatic logic lane_other(input int l);
    return (l < SAMPLES || l == 2 * SAMPLES) ? 1'b1 : 1'b0;
  endfunction

endpackage

// File: rtl/core/rotated_ellipse_pair_overlap_top.sv
// ----------------------------------------------------------------------------
// Rotated ellipse pair overlap
// Pipelined test of whether two rotated ellipses overlap, one item per cycle unless the pipeline holds.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | in_valid_i/in_stall_o | first_*_i, second_*_i
//  out     | output    | out_valid_o/out_stall_i | hit_o
//
// An item passes eight register stages, the last of them the output register;
// a new item can enter every cycle in which the pipeline does not hold.
// The depth is set by the chain of multiply stages (trig lookup, sample
// rotation, offset rotation, two squaring steps).
// Reset clears only the valid bits of the stages and the output register.
// The whole pipeline holds when the output register is full and stalled, so
// nothing is lost or repeated; in_stall_o is high exactly then.
//
// Work per item: 2*SAMPLES boundary points and both centers are each tested
// in a lane of their own against the other ellipse, in parallel, while the
// broad-phase distance check runs alongside; the lanes are ORed at the end.
module rotated_ellipse_pair_overlap_top
  import repo_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] first_center_x_i,
  input  logic signed [23:0] first_center_y_i,
  input  logic [15:0]        first_radius_h_i,
  input  logic [15:0]        first_radius_v_i,
  input  logic [15:0]        first_angle_i,
  input  logic signed [23:0] second_center_x_i,
  input  logic signed [23:0] second_center_y_i,
  input  logic [15:0]        second_radius_h_i,
  input  logic [15:0]        second_radius_v_i,
  input  logic [15:0]        second_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o
);

  logic adv;
  logic [7:1] v_q;
  logic out_valid_q;
  logic hit_q;
  logic hit_d;

  // The pipeline moves whenever the output register can take a new value.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // ---------------- stage 1: table lookups, sample offsets ----------------
  geo_t                     gin [2];
  logic [15:0]              ang [2];
  logic [TRIG_INDEX_BITS-1:0] tidx [4];
  logic [QA_W-1:0]          taddr [4];
  logic                     tneg_in [4];
  logic signed [32:0]       pex [2][SAMPLES];
  logic signed [32:0]       pey [2][SAMPLES];
  logic signed [24:0]       bdx_d;
  logic signed [24:0]       bdy_d;

  geo_t               g1_q [2];
  logic [14:0]        tmag_q [4];
  logic               tneg_q [4];
  logic signed [17:0] ex_q [2][SAMPLES];
  logic signed [17:0] ey_q [2][SAMPLES];
  logic signed [24:0] bdx_q;
  logic signed [24:0] bdy_q;

  always_comb begin
    gin[0] = '{cx: first_center_x_i, cy: first_center_y_i,
               rh: first_radius_h_i, rv: first_radius_v_i};
    gin[1] = '{cx: second_center_x_i, cy: second_center_y_i,
               rh: second_radius_h_i, rv: second_radius_v_i};
    ang[0] = first_angle_i;
    ang[1] = second_angle_i;
    // Entries 2e hold the cosine and 2e+1 the sine of ellipse e.
    for (int e = 0; e < 2; e++) begin
      tidx[2*e]   = ang[e][15 -: TRIG_INDEX_BITS] + TRIG_INDEX_BITS'(TRIG_Q);
      tidx[2*e+1] = ang[e][15 -: TRIG_INDEX_BITS];
    end
    // Fold each index onto the quarter wave; odd quadrants run backward.
    for (int t = 0; t < 4; t++) begin
      if (tidx[t][TRIG_INDEX_BITS-2]) begin
        taddr[t] = QA_W'(TRIG_Q) - {1'b0, tidx[t][TRIG_INDEX_BITS-3:0]};
      end else begin
        taddr[t] = {1'b0, tidx[t][TRIG_INDEX_BITS-3:0]};
      end
      tneg_in[t] = tidx[t][TRIG_INDEX_BITS-1];
    end
    for (int e = 0; e < 2; e++) begin
      for (int k = 0; k < SAMPLES; k++) begin
        pex[e][k] = $signed({1'b0, gin[e].rh}) * SAMP_COS[k];
        pey[e][k] = $signed({1'b0, gin[e].rv}) * SAMP_SIN[k];
      end
    end
    bdx_d = 25'(first_center_x_i) - 25'(second_center_x_i);
    bdy_d = 25'(first_center_y_i) - 25'(second_center_y_i);
  end

  // ---------------- stage 2: signed trig, sample rotation ----------------
  ell_t               ell_d [2];
  logic signed [33:0] prxc [2][SAMPLES];
  logic signed [33:0] prys [2][SAMPLES];
  logic signed [33:0] prxs [2][SAMPLES];
  logic signed [33:0] pryc [2][SAMPLES];
  logic signed [49:0] sqx;
  logic signed [49:0] sqy;
  logic [16:0]        bound;

  ell_t               e2_q [2];
  logic signed [18:0] rxc_q [2][SAMPLES];
  logic signed [18:0] rys_q [2][SAMPLES];
  logic signed [18:0] rxs_q [2][SAMPLES];
  logic signed [18:0] ryc_q [2][SAMPLES];
  logic [48:0]        dx2_q;
  logic [48:0]        dy2_q;
  logic [33:0]        bnd2_q;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      ell_d[e].g = g1_q[e];
      ell_d[e].c = tneg_q[2*e] ? -$signed({1'b0, tmag_q[2*e]})
                               : $signed({1'b0, tmag_q[2*e]});
      ell_d[e].s = tneg_q[2*e+1] ? -$signed({1'b0, tmag_q[2*e+1]})
                                 : $signed({1'b0, tmag_q[2*e+1]});
      for (int k = 0; k < SAMPLES; k++) begin
        prxc[e][k] = ex_q[e][k] * ell_d[e].c;
        prys[e][k] = ey_q[e][k] * ell_d[e].s;
        prxs[e][k] = ex_q[e][k] * ell_d[e].s;
        pryc[e][k] = ey_q[e][k] * ell_d[e].c;
      end
    end
    sqx   = bdx_q * bdx_q;
    sqy   = bdy_q * bdy_q;
    bound = 17'((g1_q[0].rh > g1_q[0].rv) ? g1_q[0].rh : g1_q[0].rv)
          + 17'((g1_q[1].rh > g1_q[1].rv) ? g1_q[1].rh : g1_q[1].rv);
  end

  // ---------------- stage 3: point positions, broad phase ----------------
  logic signed [25:0] px_d [LANES];
  logic signed [25:0] py_d [LANES];
  logic [49:0]        d2;

  ell_t               e3_q [2];
  logic signed [25:0] px_q [LANES];
  logic signed [25:0] py_q [LANES];
  logic               broad3_q;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      for (int k = 0; k < SAMPLES; k++) begin
        px_d[e*SAMPLES+k] = 26'(e2_q[e].g.cx) + 26'(rxc_q[e][k]) - 26'(rys_q[e][k]);
        py_d[e*SAMPLES+k] = 26'(e2_q[e].g.cy) + 26'(rxs_q[e][k]) + 26'(ryc_q[e][k]);
      end
      px_d[2*SAMPLES+e] = 26'(e2_q[e].g.cx);
      py_d[2*SAMPLES+e] = 26'(e2_q[e].g.cy);
    end
    d2 = {1'b0, dx2_q} + {1'b0, dy2_q};
  end

  // ---------------- stage 4: offset rotation into the other frame ----------
  logic signed [26:0] odx [LANES];
  logic signed [26:0] ody [LANES];
  logic signed [42:0] pdxc [LANES];
  logic signed [42:0] pdys [LANES];
  logic signed [42:0] pdyc [LANES];
  logic signed [42:0] pdxs [LANES];

  ell_t               e4_q [2];
  logic signed [27:0] dxc_q [LANES];
  logic signed [27:0] dys_q [LANES];
  logic signed [27:0] dyc_q [LANES];
  logic signed [27:0] dxs_q [LANES];
  logic               broad4_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      odx[l]  = 27'(px_q[l]) - 27'(e3_q[lane_other(l)].g.cx);
      ody[l]  = 27'(py_q[l]) - 27'(e3_q[lane_other(l)].g.cy);
      pdxc[l] = odx[l] * e3_q[lane_other(l)].c;
      pdys[l] = ody[l] * e3_q[lane_other(l)].s;
      pdyc[l] = ody[l] * e3_q[lane_other(l)].c;
      pdxs[l] = odx[l] * e3_q[lane_other(l)].s;
    end
  end

  // ---------------- stage 5: magnitudes clamped to the semi-axes ----------
  logic signed [28:0] rx [LANES];
  logic signed [28:0] ry [LANES];
  logic [28:0]        mrx [LANES];
  logic [28:0]        mry [LANES];

  ell_t        e5_q [2];
  logic [16:0] mx_q [LANES];
  logic [16:0] my_q [LANES];
  logic        broad5_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rx[l]  = 29'(dxc_q[l]) + 29'(dys_q[l]);
      ry[l]  = 29'(dyc_q[l]) - 29'(dxs_q[l]);
      mrx[l] = rx[l][28] ? 29'(-rx[l]) : 29'(rx[l]);
      mry[l] = ry[l][28] ? 29'(-ry[l]) : 29'(ry[l]);
    end
  end

  // ---------------- stage 6: scaled terms and the limit ----------------
  logic [32:0] a_q [LANES];
  logic [32:0] b_q [LANES];
  logic [31:0] lim_q [2];
  logic        broad6_q;

  // ---------------- stage 7: range flags and squares ----------------
  logic        agt_q [LANES];
  logic        bgt_q [LANES];
  logic [63:0] a2_q [LANES];
  logic [63:0] b2_q [LANES];
  logic [63:0] lim2_q [2];
  logic        broad7_q;

  // ---------------- stage 8: final compare and OR over the lanes ----------
  logic [LANES-1:0] lane_in;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_in[l] = !agt_q[l] && !bgt_q[l]
                && ({1'b0, a2_q[l]} + {1'b0, b2_q[l]} <= {1'b0, lim2_q[lane_other(l)]});
    end
    hit_d = broad7_q && (|lane_in);
  end

  // Control state: valid bits of the stages and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[6:1], in_valid_i};
      out_valid_q <= v_q[7];
    end
  end

  // Payload registers: they hold whenever the pipeline holds.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1
      for (int e = 0; e < 2; e++) begin
        g1_q[e] <= gin[e];
        for (int k = 0; k < SAMPLES; k++) begin
          ex_q[e][k] <= pex[e][k][32:15];
          ey_q[e][k] <= pey[e][k][32:15];
        end
      end
      for (int t = 0; t < 4; t++) begin
        tmag_q[t] <= QTAB[taddr[t]];
        tneg_q[t] <= tneg_in[t];
      end
      bdx_q <= bdx_d;
      bdy_q <= bdy_d;
      // stage 2
      for (int e = 0; e < 2; e++) begin
        e2_q[e] <= ell_d[e];
        for (int k = 0; k < SAMPLES; k++) begin
          rxc_q[e][k] <= prxc[e][k][33:15];
          rys_q[e][k] <= prys[e][k][33:15];
          rxs_q[e][k] <= prxs[e][k][33:15];
          ryc_q[e][k] <= pryc[e][k][33:15];
        end
      end
      dx2_q  <= sqx[48:0];
      dy2_q  <= sqy[48:0];
      bnd2_q <= bound * bound;
      // stage 3
      e3_q     <= e2_q;
      px_q     <= px_d;
      py_q     <= py_d;
      broad3_q <= (d2 <= 50'(bnd2_q));
      // stage 4
      e4_q     <= e3_q;
      broad4_q <= broad3_q;
      for (int l = 0; l < LANES; l++) begin
        dxc_q[l] <= pdxc[l][42:15];
        dys_q[l] <= pdys[l][42:15];
        dyc_q[l] <= pdyc[l][42:15];
        dxs_q[l] <= pdxs[l][42:15];
      end
      // stage 5
      e5_q     <= e4_q;
      broad5_q <= broad4_q;
      for (int l = 0; l < LANES; l++) begin
        mx_q[l] <= (mrx[l] > 29'(e4_q[lane_other(l)].g.rh))
                   ? (17'(e4_q[lane_other(l)].g.rh) + 17'd1) : mrx[l][16:0];
        my_q[l] <= (mry[l] > 29'(e4_q[lane_other(l)].g.rv))
                   ? (17'(e4_q[lane_other(l)].g.rv) + 17'd1) : mry[l][16:0];
      end
      // stage 6
      broad6_q <= broad5_q;
      for (int l = 0; l < LANES; l++) begin
        a_q[l] <= mx_q[l] * e5_q[lane_other(l)].g.rv;
        b_q[l] <= my_q[l] * e5_q[lane_other(l)].g.rh;
      end
      for (int e = 0; e < 2; e++) begin
        lim_q[e] <= e5_q[e].g.rh * e5_q[e].g.rv;
      end
      // stage 7: a term above the limit is a miss, so only 32 bits are squared.
      broad7_q <= broad6_q;
      for (int l = 0; l < LANES; l++) begin
        agt_q[l] <= a_q[l] > {1'b0, lim_q[lane_other(l)]};
        bgt_q[l] <= b_q[l] > {1'b0, lim_q[lane_other(l)]};
        a2_q[l]  <= a_q[l][31:0] * a_q[l][31:0];
        b2_q[l]  <= b_q[l][31:0] * b_q[l][31:0];
      end
      for (int e = 0; e < 2; e++) begin
        lim2_q[e] <= lim_q[e] * lim_q[e];
      end
      // output
      hit_q <= hit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

endmodule
